// ===== design/lptb_pkg.sv =====
// ----------------------------------------------------------------------------
// lptb_pkg
// Shared types, constants and helper functions for the link packet time
// budget pipeline.
// ----------------------------------------------------------------------------
package lptb_pkg;

  // Packet mode classes
  localparam logic [1:0] CLS_CODED = 2'd0;
  localparam logic [1:0] CLS_RATE1 = 2'd1;
  localparam logic [1:0] CLS_RATE2 = 2'd2;
  localparam logic [1:0] CLS_BAD   = 2'd3;

  // Airtime constants
  localparam logic [7:0]  CODED_MASK     = 8'h0c;
  localparam logic [15:0] CODED_BASE     = 16'h03d0;
  localparam logic [15:0] CODED_CAP      = 16'h0a90;
  localparam logic [15:0] CODED_FLOOR    = 16'h0e90;
  localparam logic [15:0] RATE1_FLOOR    = 16'h01c8;
  localparam logic [15:0] RATE2_FLOOR    = 16'h00e8;
  localparam logic [15:0] RATE1_PAD      = 16'd14;
  localparam logic [15:0] RATE2_PAD      = 16'd15;
  localparam logic [31:0] INTERVAL_LIMIT = 32'h0000_1d4c;

  // Fixed extra plus two gaps, short and long
  localparam int unsigned TOTAL_W = 18;
  localparam logic [TOTAL_W-1:0] FIXED_SHORT = TOTAL_W'(6 + 2 * 32'h4d);
  localparam logic [TOTAL_W-1:0] FIXED_LONG  = TOTAL_W'(6 + 2 * 32'h96);

  // Stage 1 -> stage 2 word
  typedef struct packed {
    logic        err;
    logic [1:0]  cls1;
    logic [1:0]  cls2;
    logic [15:0] raw1;
    logic [15:0] raw2;
    logic [15:0] cap1;
    logic [15:0] cap2;
    logic        gap_long;
    logic [31:0] avail;
    logic [15:0] span;
  } s1_t;

  // Stage 2 -> stage 3 word
  typedef struct packed {
    logic        err;
    logic [15:0] t1;
    logic [15:0] t2;
    logic        gap_long;
    logic [31:0] avail;
    logic [15:0] span;
  } s2_t;

  // Stage 3 result word
  typedef struct packed {
    logic        err;
    logic [31:0] remaining;
  } res_t;

  // Pipeline stage enables
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } pipe_en_t;

  function automatic logic [1:0] mode_class(input logic [7:0] mode);
    logic [1:0] c;
    if ((mode & CODED_MASK) != 8'd0) c = CLS_CODED;
    else if (mode == 8'd1)           c = CLS_RATE1;
    else if (mode == 8'd2)           c = CLS_RATE2;
    else                             c = CLS_BAD;
    return c;
  endfunction

  // Airtime before any cap, wrapped to 16 bits
  function automatic logic [15:0] raw_airtime(input logic [1:0] cls,
                                              input logic [15:0] len);
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] r;
    p1 = len + RATE1_PAD;
    p2 = len + RATE2_PAD;
    unique case (cls)
      CLS_CODED: r = {len[9:0], 6'b0} + CODED_BASE;
      CLS_RATE1: r = {p1[12:0], 3'b0};
      CLS_RATE2: r = {p2[13:0], 2'b0};
      default:   r = 16'd0;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] floor_of(input logic [1:0] cls);
    logic [15:0] f;
    unique case (cls)
      CLS_CODED: f = CODED_FLOOR;
      CLS_RATE1: f = RATE1_FLOOR;
      default:   f = RATE2_FLOOR;
    endcase
    return f;
  endfunction

endpackage

// ===== design/lptb_stage_raw.sv =====
// ----------------------------------------------------------------------------
// lptb_stage_raw
// Stage 1: classifies both modes, forms raw airtimes, folds the two primary
// limits into one and selects the gap.
// ----------------------------------------------------------------------------
module lptb_stage_raw (
  input  logic              clk,
  input  logic              en,
  input  logic [7:0]        first_mode,
  input  logic [7:0]        second_mode,
  input  logic [31:0]       interval_value,
  input  logic [15:0]       first_length,
  input  logic [15:0]       second_length,
  input  logic [15:0]       first_cap_a,
  input  logic [15:0]       first_cap_b,
  input  logic [15:0]       second_cap,
  input  logic [31:0]       available_time,
  input  logic [15:0]       extra_span,
  output lptb_pkg::s1_t     s1
);

  lptb_pkg::s1_t s1_r;
  lptb_pkg::s1_t s1_nxt;

  // Decode and raw airtime
  always_comb begin
    s1_nxt.cls1     = lptb_pkg::mode_class(first_mode);
    s1_nxt.cls2     = lptb_pkg::mode_class(second_mode);
    s1_nxt.err      = (s1_nxt.cls1 == lptb_pkg::CLS_BAD) ||
                      (s1_nxt.cls2 == lptb_pkg::CLS_BAD);
    s1_nxt.raw1     = lptb_pkg::raw_airtime(s1_nxt.cls1, first_length);
    s1_nxt.raw2     = lptb_pkg::raw_airtime(s1_nxt.cls2, second_length);
    s1_nxt.cap1     = (first_cap_a < first_cap_b) ? first_cap_a : first_cap_b;
    s1_nxt.cap2     = second_cap;
    s1_nxt.gap_long = !(interval_value < lptb_pkg::INTERVAL_LIMIT);
    s1_nxt.avail    = available_time;
    s1_nxt.span     = extra_span;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
    end
  end

  assign s1 = s1_r;

endmodule

// ===== design/lptb_stage_limit.sv =====
// ----------------------------------------------------------------------------
// lptb_stage_limit
// Stage 2: applies the caps and the optional per-mode floor to each airtime.
// ----------------------------------------------------------------------------
module lptb_stage_limit (
  input  logic              clk,
  input  logic              en,
  input  logic              floor_en,
  input  lptb_pkg::s1_t     s1,
  output lptb_pkg::s2_t     s2
);

  lptb_pkg::s2_t s2_r;
  lptb_pkg::s2_t s2_nxt;
  logic [15:0]   lim1;
  logic [15:0]   lim2;
  logic [15:0]   fl1;
  logic [15:0]   fl2;
  logic [15:0]   c1;
  logic [15:0]   c2;

  // Cap then floor
  always_comb begin
    lim1 = (s1.cls1 == lptb_pkg::CLS_CODED) ? lptb_pkg::CODED_CAP : s1.cap1;
    lim2 = (s1.cls2 == lptb_pkg::CLS_CODED) ? lptb_pkg::CODED_CAP : s1.cap2;
    c1   = (s1.raw1 < lim1) ? s1.raw1 : lim1;
    c2   = (s1.raw2 < lim2) ? s1.raw2 : lim2;
    fl1  = lptb_pkg::floor_of(s1.cls1);
    fl2  = lptb_pkg::floor_of(s1.cls2);
    s2_nxt.t1       = (floor_en && c1 < fl1) ? fl1 : c1;
    s2_nxt.t2       = (floor_en && c2 < fl2) ? fl2 : c2;
    s2_nxt.err      = s1.err;
    s2_nxt.gap_long = s1.gap_long;
    s2_nxt.avail    = s1.avail;
    s2_nxt.span     = s1.span;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r <= s2_nxt;
    end
  end

  assign s2 = s2_r;

endmodule

// ===== design/lptb_stage_total.sv =====
// ----------------------------------------------------------------------------
// lptb_stage_total
// Stage 3: sums the deductions and subtracts from the available time,
// saturating at zero; an invalid mode forces zero.
// ----------------------------------------------------------------------------
module lptb_stage_total (
  input  logic              clk,
  input  logic              en,
  input  lptb_pkg::s2_t     s2,
  output lptb_pkg::res_t    res
);

  lptb_pkg::res_t                 res_r;
  lptb_pkg::res_t                 res_nxt;
  logic [lptb_pkg::TOTAL_W-1:0]   total;
  logic [31:0]                    total_ext;

  // Total fits in 18 bits, so no wrap
  always_comb begin
    total = lptb_pkg::TOTAL_W'(s2.t1) + lptb_pkg::TOTAL_W'(s2.t2) +
            lptb_pkg::TOTAL_W'(s2.span) +
            (s2.gap_long ? lptb_pkg::FIXED_LONG : lptb_pkg::FIXED_SHORT);
    total_ext = 32'(total);
    res_nxt.err = s2.err;
    if (s2.err || s2.avail < total_ext) begin
      res_nxt.remaining = 32'd0;
    end else begin
      res_nxt.remaining = s2.avail - total_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// ===== design/link_packet_time_budget.sv =====
// ----------------------------------------------------------------------------
// link_packet_time_budget
// Time left in a link budget after two packet airtimes, an extra span and
// fixed gaps.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on in_valid/in_ready; each one gives exactly one
//   result word on out_valid/out_ready (remaining time and mode error flag).
//   Three register stages: decode and raw airtime, cap and floor, then sum
//   and saturating subtract. The last stage is the output register.
//   An accepted word moves through the three stage registers in order and is
//   shown on out_* from the last. The pipeline takes one word per cycle
//   while out_ready does not stall it. cfg_we/cfg_wdata write the floor
//   enable; write it only while no word is in flight.
//   Reset (rst_n low, synchronous) empties the pipeline and clears the floor
//   enable. When out_ready is low, held words stay in their stages and a
//   stage takes a new word only when it is empty or moving on; in_ready
//   drops once all three stages hold words and out_ready is low.
// ----------------------------------------------------------------------------
module link_packet_time_budget (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_first_mode,
  input  logic [7:0]  in_second_mode,
  input  logic [31:0] in_interval_value,
  input  logic [15:0] in_first_length,
  input  logic [15:0] in_second_length,
  input  logic [15:0] in_first_cap_a,
  input  logic [15:0] in_first_cap_b,
  input  logic [15:0] in_second_cap,
  input  logic [31:0] in_available_time,
  input  logic [15:0] in_extra_span,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_remaining_time,
  output logic        out_mode_error
);

  logic               floor_en_r;
  logic [2:0]         vld_r;
  logic [2:0]         vld_nxt;
  lptb_pkg::pipe_en_t pen;
  lptb_pkg::s1_t      s1;
  lptb_pkg::s2_t      s2;
  lptb_pkg::res_t     res;

  // Config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_en_r <= 1'b0;
    end else if (cfg_we) begin
      floor_en_r <= cfg_wdata;
    end
  end

  // Stage enables: a stage loads when empty or when its word moves on
  always_comb begin
    pen.en3 = !vld_r[2] || out_ready;
    pen.en2 = !vld_r[1] || pen.en3;
    pen.en1 = !vld_r[0] || pen.en2;
    vld_nxt = vld_r;
    if (pen.en1) vld_nxt[0] = in_valid;
    if (pen.en2) vld_nxt[1] = vld_r[0];
    if (pen.en3) vld_nxt[2] = vld_r[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 3'b000;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  lptb_stage_raw u_raw (
    .clk            (clk),
    .en             (pen.en1),
    .first_mode     (in_first_mode),
    .second_mode    (in_second_mode),
    .interval_value (in_interval_value),
    .first_length   (in_first_length),
    .second_length  (in_second_length),
    .first_cap_a    (in_first_cap_a),
    .first_cap_b    (in_first_cap_b),
    .second_cap     (in_second_cap),
    .available_time (in_available_time),
    .extra_span     (in_extra_span),
    .s1             (s1)
  );

  lptb_stage_limit u_limit (
    .clk      (clk),
    .en       (pen.en2),
    .floor_en (floor_en_r),
    .s1       (s1),
    .s2       (s2)
  );

  lptb_stage_total u_total (
    .clk (clk),
    .en  (pen.en3),
    .s2  (s2),
    .res (res)
  );

  assign in_ready           = pen.en1;
  assign out_valid          = vld_r[2];
  assign out_remaining_time = res.remaining;
  assign out_mode_error     = res.err;

endmodule

// ===== design/lptb_checker.sv =====
// ----------------------------------------------------------------------------
// lptb_checker
// Port-level checks for link_packet_time_budget, bound to the top level.
// ----------------------------------------------------------------------------
module lptb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_remaining_time,
  input logic        out_mode_error
);

  // Stalled result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_remaining_time) &&
                                $stable(out_mode_error))
    else $error("result changed while stalled");

  // Error words carry zero remaining time
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mode_error |-> out_remaining_time == 32'd0)
    else $error("mode error with nonzero remaining time");

  // Reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  // Empty output stage means the pipeline can take a word
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty output");

endmodule

bind link_packet_time_budget lptb_checker u_lptb_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_remaining_time (out_remaining_time),
  .out_mode_error     (out_mode_error)
);

// ===== sim/lptb_tb_ledger.sv =====
// ----------------------------------------------------------------------------
// Link packet time budget scoreboard
// Word types, airtime constants and the scoreboard class. The class keeps its
// own copy of the floor enable, predicts the remaining time for each accepted
// input word and checks result words in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lptb_tb_ledger;

  // Mode encodings
  localparam logic [7:0]  CODED_BITS = 8'h0c;
  localparam logic [7:0]  MODE_RATE1 = 8'd1;
  localparam logic [7:0]  MODE_RATE2 = 8'd2;

  // Airtime arithmetic
  localparam int unsigned CODED_STEP   = 64;
  localparam int unsigned CODED_OFFSET = 976;
  localparam int unsigned CODED_LIMIT  = 2704;
  localparam int unsigned RATE1_ADD    = 14;
  localparam int unsigned RATE1_STEP   = 8;
  localparam int unsigned RATE2_ADD    = 15;
  localparam int unsigned RATE2_STEP   = 4;
  localparam int unsigned CODED_MIN    = 3728;
  localparam int unsigned RATE1_MIN    = 456;
  localparam int unsigned RATE2_MIN    = 232;

  // Gaps and fixed overhead
  localparam logic [31:0] SHORT_INTERVAL_END = 32'd7500;
  localparam int unsigned GAP_SHORT          = 77;
  localparam int unsigned GAP_LONG           = 150;
  localparam int unsigned FIXED_EXTRA        = 6;

  localparam int unsigned MAX_PRINTS = 40;

  typedef struct packed {
    logic [7:0]  first_mode;
    logic [7:0]  second_mode;
    logic [31:0] interval_value;
    logic [15:0] first_length;
    logic [15:0] second_length;
    logic [15:0] first_cap_a;
    logic [15:0] first_cap_b;
    logic [15:0] second_cap;
    logic [31:0] available_time;
    logic [15:0] extra_span;
  } budget_req_t;

  typedef struct packed {
    logic [31:0] remaining;
    logic        err;
  } budget_res_t;

  class budget_ledger;
    budget_res_t owed_results[$];
    bit          floor_on;
    int unsigned faults;
    int unsigned results_seen;

    function new();
      floor_on     = 1'b0;
      faults       = 0;
      results_seen = 0;
    endfunction

    function void set_floor(bit v);
      floor_on = v;
    endfunction

    function int unsigned pending();
      return owed_results.size();
    endfunction

    function bit is_coded(logic [7:0] m);
      return (m & CODED_BITS) != 8'd0;
    endfunction

    function bit mode_ok(logic [7:0] m);
      return is_coded(m) || m == MODE_RATE1 || m == MODE_RATE2;
    endfunction

    // Uncapped airtime, wrapped to 16 bits
    function logic [15:0] airtime(logic [7:0] m, logic [15:0] len);
      logic [31:0] wide;
      if (is_coded(m)) begin
        wide = 32'(len) * CODED_STEP + CODED_OFFSET;
      end else if (m == MODE_RATE1) begin
        wide = (32'(len) + RATE1_ADD) * RATE1_STEP;
      end else begin
        wide = (32'(len) + RATE2_ADD) * RATE2_STEP;
      end
      return wide[15:0];
    endfunction

    function logic [15:0] floor_for(logic [7:0] m);
      if (is_coded(m)) return 16'(CODED_MIN);
      if (m == MODE_RATE1) return 16'(RATE1_MIN);
      return 16'(RATE2_MIN);
    endfunction

    function budget_res_t forecast(budget_req_t r);
      budget_res_t res;
      logic [15:0] t1;
      logic [15:0] t2;
      logic [15:0] lim1;
      logic [31:0] gap;
      logic [31:0] total;
      res.err       = 1'b0;
      res.remaining = '0;
      if (!mode_ok(r.first_mode) || !mode_ok(r.second_mode)) begin
        res.err = 1'b1;
        return res;
      end
      gap = (r.interval_value < SHORT_INTERVAL_END) ? GAP_SHORT : GAP_LONG;

      // primary: coded cap, or the tighter of its two limits
      t1   = airtime(r.first_mode, r.first_length);
      lim1 = (r.first_cap_a < r.first_cap_b) ? r.first_cap_a : r.first_cap_b;
      if (is_coded(r.first_mode)) begin
        if (t1 > CODED_LIMIT) t1 = 16'(CODED_LIMIT);
      end else if (t1 > lim1) begin
        t1 = lim1;
      end

      // secondary: coded cap or its own limit
      t2 = airtime(r.second_mode, r.second_length);
      if (is_coded(r.second_mode)) begin
        if (t2 > CODED_LIMIT) t2 = 16'(CODED_LIMIT);
      end else if (t2 > r.second_cap) begin
        t2 = r.second_cap;
      end

      if (floor_on) begin
        if (t1 < floor_for(r.first_mode)) t1 = floor_for(r.first_mode);
        if (t2 < floor_for(r.second_mode)) t2 = floor_for(r.second_mode);
      end

      total = 32'(t1) + 32'(t2) + 32'(r.extra_span) + FIXED_EXTRA + 2 * gap;
      res.remaining = (r.available_time < total) ? 32'd0 : r.available_time - total;
      return res;
    endfunction

    function void note_request(budget_req_t r);
      owed_results.push_back(forecast(r));
    endfunction

    task report_mismatch(string what);
      if (faults < MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, what);
      faults++;
    endtask

    task check_result(logic [31:0] remaining, logic err);
      budget_res_t want;
      results_seen++;
      if (owed_results.size() == 0) begin
        report_mismatch($sformatf("result word %0d with nothing owed", results_seen));
        return;
      end
      want = owed_results.pop_front();
      if (remaining !== want.remaining)
        report_mismatch($sformatf("word %0d remaining_time %0d, expected %0d",
                                  results_seen, remaining, want.remaining));
      if (err !== want.err)
        report_mismatch($sformatf("word %0d mode_error %b, expected %b",
                                  results_seen, err, want.err));
    endtask
  endclass

endpackage

// ===== sim/tb_link_packet_time_budget.sv =====
// ----------------------------------------------------------------------------
// tb_link_packet_time_budget
// Drives directed and random words into the time budget block with random
// idling on both channels, toggles the floor enable between phases, and
// checks every result word against the scoreboard's prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_link_packet_time_budget;
  import lptb_tb_ledger::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned PHASE_WORDS   = 255;
  localparam int unsigned PHASES        = 6;
  localparam int unsigned SQUEEZE_AT    = 400;
  localparam int unsigned SQUEEZE_LEN   = 250;
  localparam int unsigned TAIL_CYCLES   = 12;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_first_mode = '0;
  logic [7:0]  in_second_mode = '0;
  logic [31:0] in_interval_value = '0;
  logic [15:0] in_first_length = '0;
  logic [15:0] in_second_length = '0;
  logic [15:0] in_first_cap_a = '0;
  logic [15:0] in_first_cap_b = '0;
  logic [15:0] in_second_cap = '0;
  logic [31:0] in_available_time = '0;
  logic [15:0] in_extra_span = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_remaining_time;
  logic        out_mode_error;

  budget_ledger ledger = new();
  int unsigned  cycle_count = 0;
  int unsigned  send_calm = 0;
  bit           floor_now = 1'b0;

  link_packet_time_budget DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_first_mode     (in_first_mode),
    .in_second_mode    (in_second_mode),
    .in_interval_value (in_interval_value),
    .in_first_length   (in_first_length),
    .in_second_length  (in_second_length),
    .in_first_cap_a    (in_first_cap_a),
    .in_first_cap_b    (in_first_cap_b),
    .in_second_cap     (in_second_cap),
    .in_available_time (in_available_time),
    .in_extra_span     (in_extra_span),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_remaining_time(out_remaining_time),
    .out_mode_error    (out_mode_error)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_link_packet_time_budget NOT OK");
      $finish;
    end
  end

  // Idle length: mostly none or short, a few long, with calm stretches
  function automatic int unsigned idle_len(ref int unsigned calm);
    int unsigned roll;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic budget_req_t word(logic [7:0] m1, logic [7:0] m2,
                                       logic [31:0] ivl, logic [15:0] l1,
                                       logic [15:0] l2, logic [15:0] ca,
                                       logic [15:0] cb, logic [15:0] c2,
                                       logic [31:0] avail, logic [15:0] span);
    budget_req_t w;
    w.first_mode     = m1;
    w.second_mode    = m2;
    w.interval_value = ivl;
    w.first_length   = l1;
    w.second_length  = l2;
    w.first_cap_a    = ca;
    w.first_cap_b    = cb;
    w.second_cap     = c2;
    w.available_time = avail;
    w.extra_span     = span;
    return w;
  endfunction

  // Mostly valid modes; the rest is any byte, valid or not
  function automatic logic [7:0] random_mode();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll < 7) return 8'($urandom_range(0, 255)) | (8'($urandom_range(1, 3)) << 2);
    if (roll < 12) return MODE_RATE1;
    if (roll < 17) return MODE_RATE2;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [15:0] random_length();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 5) return 16'($urandom_range(0, 60));
    if (roll < 8) return 16'($urandom);
    if (roll < 9) return 16'($urandom_range(1000, 1100));
    return 16'($urandom_range(65500, 65535));
  endfunction

  function automatic logic [15:0] random_cap();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) return 16'($urandom);
    if (roll < 7) return 16'($urandom_range(0, 600));
    return 16'hffff;
  endfunction

  function automatic budget_req_t random_word();
    budget_req_t w;
    int unsigned roll;
    w.first_mode    = random_mode();
    w.second_mode   = random_mode();
    w.first_length  = random_length();
    w.second_length = random_length();
    w.first_cap_a   = random_cap();
    w.first_cap_b   = random_cap();
    w.second_cap    = random_cap();
    w.extra_span    = ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'($urandom_range(0, 100));

    roll = $urandom_range(0, 19);
    if (roll < 6) w.interval_value = $urandom_range(7495, 7505);
    else if (roll < 13) w.interval_value = $urandom_range(0, 7499);
    else w.interval_value = $urandom;

    // keep many budgets near the total so saturation shows up
    roll = $urandom_range(0, 9);
    if (roll < 4) w.available_time = $urandom;
    else if (roll < 8) w.available_time = $urandom_range(0, 200000);
    else if (roll < 9) w.available_time = 32'hffff_ffff;
    else w.available_time = '0;
    return w;
  endfunction

  // Offer one word and hold it until accepted; called and returns at posedge
  task automatic send_word(input budget_req_t w);
    int unsigned gap;
    gap = idle_len(send_calm);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_first_mode     <= w.first_mode;
    in_second_mode    <= w.second_mode;
    in_interval_value <= w.interval_value;
    in_first_length   <= w.first_length;
    in_second_length  <= w.second_length;
    in_first_cap_a    <= w.first_cap_a;
    in_first_cap_b    <= w.first_cap_b;
    in_second_cap     <= w.second_cap;
    in_available_time <= w.available_time;
    in_extra_span     <= w.extra_span;
    // ready seen mid-cycle means the word goes in at the next edge
    do @(negedge clk); while (in_ready !== 1'b1);
    @(posedge clk);
    ledger.note_request(w);
  endtask

  // Stop offering and wait until every owed result is back
  task automatic drain();
    in_valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  task automatic write_floor(input bit v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    ledger.set_floor(v);
    floor_now = v;
  endtask

  // Result side: random stalls, plus one long hold to back up the pipeline
  initial begin : result_sink
    int unsigned hold;
    int unsigned calm;
    bit          squeezed;
    hold     = 0;
    calm     = 0;
    squeezed = 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (!squeezed && ledger.results_seen >= SQUEEZE_AT) begin
        squeezed = 1'b1;
        hold     = SQUEEZE_LEN;
      end else if (hold == 0) begin
        hold = idle_len(calm);
      end
      if (hold != 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  // Sample the result handshake mid-cycle, away from the driving edge
  always @(negedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
      ledger.check_result(out_remaining_time, out_mode_error);
  end

  initial begin : stimulus
    bit want_floor;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, floor off
    send_word(word(8'd0, 8'd0, '0, '0, '0, '0, '0, '0, '0, '0));
    send_word(word(8'hff, 8'hff, '1, '1, '1, '1, '1, '1, '1, '1));
    send_word(word(MODE_RATE1, MODE_RATE1, 32'd7499, 16'd0, 16'd0,
                   '1, '1, '1, '1, 16'd0));
    send_word(word(MODE_RATE2, MODE_RATE2, 32'd7500, 16'd0, 16'd0,
                   '1, '1, '1, '1, 16'd0));
    // coded: exactly at the cap and just over it
    send_word(word(8'd4, 8'd8, 32'd100, 16'd27, 16'd28, '0, '0, '0, '1, 16'd5));
    send_word(word(8'd12, MODE_RATE1, '1, 16'd300, 16'd300, '1, '1, 16'd0, '1, 16'd0));
    // each of the two primary limits being the tighter one
    send_word(word(MODE_RATE1, MODE_RATE2, '0, 16'd500, 16'd500,
                   16'd100, 16'd9000, '1, '1, '1));
    send_word(word(MODE_RATE1, MODE_RATE2, '0, 16'd500, 16'd500,
                   16'd9000, 16'd200, '1, '1, '1));
    // invalid modes on either side
    send_word(word(8'd3, MODE_RATE1, '0, '0, '0, '1, '1, '1, '1, '0));
    send_word(word(MODE_RATE1, 8'd0, '0, '0, '0, '1, '1, '1, '1, '0));
    send_word(word(MODE_RATE2, 8'd16, '0, '0, '0, '1, '1, '1, '1, '0));
    // 16-bit wrap of each formula
    send_word(word(MODE_RATE1, MODE_RATE2, '0, '1, '1, '1, '1, '1, '1, '0));
    send_word(word(8'd4, 8'd8, 32'd7499, 16'd1009, 16'd1024, '0, '0, '0, '1, '0));
    // total 384: budget one under, equal, one over
    send_word(word(MODE_RATE1, MODE_RATE1, '0, '0, '0, '1, '1, '1, 32'd383, '0));
    send_word(word(MODE_RATE1, MODE_RATE1, '0, '0, '0, '1, '1, '1, 32'd384, '0));
    send_word(word(MODE_RATE1, MODE_RATE1, '0, '0, '0, '1, '1, '1, 32'd385, '0));
    send_word(word(8'hf0, 8'h0f, '1, 16'h5555, 16'haaaa, 16'haaaa, 16'h5555,
                   16'h5555, 32'haaaa_5555, 16'haaaa));

    // Directed, floor on
    drain();
    write_floor(1'b1);
    send_word(word(8'd4, 8'd8, '0, '0, '0, '0, '0, '0, '1, '0));
    send_word(word(MODE_RATE1, MODE_RATE1, '0, '0, '0, '0, '0, '0, '1, '0));
    send_word(word(MODE_RATE2, MODE_RATE2, '1, '0, 16'd2000, '1, '1, '1, '1, '0));
    send_word(word(8'd0, MODE_RATE1, '0, '0, '0, '1, '1, '1, '1, '0));
    send_word(word(8'hff, 8'hff, '1, '1, '1, '1, '1, '1, '1, '1));
    send_word(word(MODE_RATE1, 8'd4, '0, '1, 16'd100, '1, '1, '1, 32'd4000, '0));

    // Random phases, floor alternating
    for (int p = 0; p < PHASES; p++) begin
      want_floor = (p % 2) == 0;
      if (want_floor != floor_now) begin
        drain();
        write_floor(want_floor);
      end
      for (int i = 0; i < PHASE_WORDS; i++) send_word(random_word());
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (ledger.faults == 0 && ledger.pending() == 0) begin
      $display("tb_link_packet_time_budget OK");
    end else begin
      $display("tb_link_packet_time_budget NOT OK");
    end
    $finish;
  end

endmodule
